// ===== hdl/bounded_array_list_engine_defines.svh =====
// Assertion macros for the list engine.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef BOUNDED_ARRAY_LIST_ENGINE_DEFINES_SVH
`define BOUNDED_ARRAY_LIST_ENGINE_DEFINES_SVH

`ifndef ASSERT_OFF
`define BALE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define BALE_ASSERT_NEVER(label, prop, msg) \
	`BALE_ASSERT(label, !(prop), msg)
`else
`define BALE_ASSERT(label, prop, msg)
`define BALE_ASSERT_NEVER(label, prop, msg)
`endif

`endif

// ===== hdl/bal_pkg.sv =====
package bal_pkg;

	// storage and field sizes
	localparam int MAX_ENTRIES = 64;
	localparam int ADDR_W      = $clog2(MAX_ENTRIES);
	localparam int LEN_W       = $clog2(MAX_ENTRIES + 1);
	localparam int DATA_W      = 32;
	localparam int CMD_W       = 4;
	localparam int POS_W       = 6;
	localparam int CAP_W       = 7;
	localparam int OUT_CNT_W   = 7;
	localparam int CMP_W       = (LEN_W > POS_W) ? ((LEN_W > CAP_W) ? LEN_W : CAP_W)
	                                             : ((POS_W > CAP_W) ? POS_W : CAP_W);
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	typedef logic [ADDR_W-1:0]    addr_t;
	typedef logic [LEN_W-1:0]     len_t;
	typedef logic [CMP_W-1:0]     cmp_t;
	typedef logic [DATA_W-1:0]    data_t;
	typedef logic [CAP_W-1:0]     cap_t;
	typedef logic [OUT_CNT_W-1:0] cnt_out_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_INS_FRONT  = 4'd0,
		CMD_INS_REAR   = 4'd1,
		CMD_INS_AT     = 4'd2,
		CMD_INS_SORTED = 4'd3,
		CMD_DEL_FRONT  = 4'd4,
		CMD_DEL_REAR   = 4'd5,
		CMD_DEL_AT     = 4'd6,
		CMD_DEL_FIRST  = 4'd7,
		CMD_DEL_ALL    = 4'd8,
		CMD_SEARCH     = 4'd9,
		CMD_READ_AT    = 4'd10,
		CMD_COUNT      = 4'd11
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_WR,
		ST_SCAN_RD,
		ST_SCAN_EV,
		ST_READ_RD,
		ST_READ_EV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [CMD_W-1:0]        command;
		logic signed [DATA_W-1:0] item;
		logic [POS_W-1:0]        position;
	} in_word_t;

	typedef struct packed {
		logic                     ok;
		logic                     found;
		logic signed [DATA_W-1:0] value;
		logic [OUT_CNT_W-1:0]     match_count;
		logic [OUT_CNT_W-1:0]     length;
	} out_word_t;

	typedef struct packed {
		logic  we;
		addr_t waddr;
		data_t wdata;
		addr_t raddr;
	} mem_req_t;

endpackage

// ===== hdl/bal_ram.sv =====
module bal_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/bal_engine.sv =====
`include "bounded_array_list_engine_defines.svh"

module bal_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  bal_pkg::in_word_t   in_word,
	input  bal_pkg::cap_t       capacity,
	output bal_pkg::mem_req_t   mem_req,
	input  bal_pkg::data_t      mem_rdata,
	output logic                res_valid,
	input  logic                res_free,
	output bal_pkg::out_word_t  res_word
);

	bal_pkg::state_t state_q, state_d;
	bal_pkg::len_t   used_q;
	bal_pkg::cmd_t   cmd_q;
	bal_pkg::data_t  item_q;
	bal_pkg::len_t   idx_q;
	bal_pkg::len_t   tgt_q;
	bal_pkg::len_t   wr_q;
	bal_pkg::len_t   cnt_q;
	logic            ok_q;
	logic            found_q;
	bal_pkg::data_t  value_q;

	bal_pkg::cmd_t   cmd_in;
	logic            accept;
	bal_pkg::cmp_t   cap_ext, max_ext, eff_cap, used_ext, pos_ext;
	logic            can_ins;
	bal_pkg::state_t start_state;
	bal_pkg::len_t   start_tgt;
	bal_pkg::len_t   idx_dec;
	logic            is_del;
	logic            is_sorted;
	logic            rd_gt;
	logic            rd_match;
	logic            drop;
	logic            scan_end;
	logic            found_out;
	logic            cnt_out;

	assign cmd_in   = bal_pkg::cmd_t'(in_word.command);
	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != bal_pkg::ST_IDLE);

	// effective capacity and insert room
	assign cap_ext  = bal_pkg::cmp_t'(capacity);
	assign max_ext  = bal_pkg::cmp_t'(bal_pkg::MAX_ENTRIES);
	assign eff_cap  = (cap_ext > max_ext) ? max_ext : cap_ext;
	assign used_ext = bal_pkg::cmp_t'(used_q);
	assign pos_ext  = bal_pkg::cmp_t'(in_word.position);
	assign can_ins  = used_ext < eff_cap;

	assign idx_dec   = idx_q - bal_pkg::len_t'(1);
	assign is_sorted = (cmd_q == bal_pkg::CMD_INS_SORTED);
	assign rd_gt     = $signed(mem_rdata) > $signed(item_q);
	assign rd_match  = (mem_rdata == item_q);
	assign scan_end  = (idx_q == used_q);

	// decode the held command
	always_comb begin
		is_del    = 1'b0;
		found_out = 1'b0;
		cnt_out   = 1'b0;
		drop      = 1'b0;
		case (cmd_q) inside
			bal_pkg::CMD_DEL_FRONT, bal_pkg::CMD_DEL_AT: begin
				is_del = 1'b1;
				drop   = (idx_q == tgt_q);
			end
			bal_pkg::CMD_DEL_FIRST: begin
				is_del    = 1'b1;
				found_out = 1'b1;
				drop      = rd_match && !found_q;
			end
			bal_pkg::CMD_DEL_ALL: begin
				is_del    = 1'b1;
				found_out = 1'b1;
				cnt_out   = 1'b1;
				drop      = rd_match;
			end
			bal_pkg::CMD_SEARCH: found_out = 1'b1;
			bal_pkg::CMD_COUNT:  cnt_out = 1'b1;
			default: ;
		endcase
	end

	// pick the first state and target for a new word
	always_comb begin
		start_state = bal_pkg::ST_DONE;
		start_tgt   = '0;
		case (cmd_in) inside
			bal_pkg::CMD_INS_FRONT, bal_pkg::CMD_INS_SORTED: begin
				if (can_ins) start_state = bal_pkg::ST_INS_RD;
			end
			bal_pkg::CMD_INS_REAR: begin
				start_tgt = used_q;
				if (can_ins) start_state = bal_pkg::ST_INS_RD;
			end
			bal_pkg::CMD_INS_AT: begin
				start_tgt = bal_pkg::len_t'(in_word.position);
				if (can_ins && pos_ext <= used_ext) start_state = bal_pkg::ST_INS_RD;
			end
			bal_pkg::CMD_DEL_FRONT: begin
				if (used_q != '0) start_state = bal_pkg::ST_SCAN_RD;
			end
			bal_pkg::CMD_DEL_AT: begin
				start_tgt = bal_pkg::len_t'(in_word.position);
				if (pos_ext < used_ext) start_state = bal_pkg::ST_SCAN_RD;
			end
			bal_pkg::CMD_DEL_FIRST, bal_pkg::CMD_DEL_ALL,
			bal_pkg::CMD_SEARCH, bal_pkg::CMD_COUNT: begin
				start_state = bal_pkg::ST_SCAN_RD;
			end
			bal_pkg::CMD_READ_AT: begin
				start_tgt = bal_pkg::len_t'(in_word.position);
				if (pos_ext < used_ext) start_state = bal_pkg::ST_READ_RD;
			end
			default: ;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bal_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and memory port
	always_comb begin
		state_d       = state_q;
		mem_req       = '0;
		mem_req.raddr = idx_q[bal_pkg::ADDR_W-1:0];
		res_valid     = 1'b0;
		unique case (state_q)
			bal_pkg::ST_IDLE: begin
				if (accept) state_d = start_state;
			end
			bal_pkg::ST_INS_RD: begin
				if (idx_q == tgt_q) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = idx_q[bal_pkg::ADDR_W-1:0];
					mem_req.wdata = item_q;
					state_d       = bal_pkg::ST_DONE;
				end else begin
					mem_req.raddr = idx_dec[bal_pkg::ADDR_W-1:0];
					state_d       = bal_pkg::ST_INS_WR;
				end
			end
			bal_pkg::ST_INS_WR: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = idx_q[bal_pkg::ADDR_W-1:0];
				if (is_sorted && !rd_gt) begin
					mem_req.wdata = item_q;
					state_d       = bal_pkg::ST_DONE;
				end else begin
					mem_req.wdata = mem_rdata;
					state_d       = bal_pkg::ST_INS_RD;
				end
			end
			bal_pkg::ST_SCAN_RD: begin
				state_d = scan_end ? bal_pkg::ST_DONE : bal_pkg::ST_SCAN_EV;
			end
			bal_pkg::ST_SCAN_EV: begin
				mem_req.we    = is_del && !drop;
				mem_req.waddr = wr_q[bal_pkg::ADDR_W-1:0];
				mem_req.wdata = mem_rdata;
				state_d       = bal_pkg::ST_SCAN_RD;
			end
			bal_pkg::ST_READ_RD: begin
				mem_req.raddr = tgt_q[bal_pkg::ADDR_W-1:0];
				state_d       = bal_pkg::ST_READ_EV;
			end
			bal_pkg::ST_READ_EV: begin
				state_d = bal_pkg::ST_DONE;
			end
			bal_pkg::ST_DONE: begin
				res_valid = 1'b1;
				if (res_free) state_d = bal_pkg::ST_IDLE;
			end
		endcase
	end

	// list length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else begin
			if (accept && cmd_in == bal_pkg::CMD_DEL_REAR && used_q != '0) begin
				used_q <= used_q - bal_pkg::len_t'(1);
			end else if ((state_q == bal_pkg::ST_INS_RD && idx_q == tgt_q) ||
			             (state_q == bal_pkg::ST_INS_WR && is_sorted && !rd_gt)) begin
				used_q <= used_q + bal_pkg::len_t'(1);
			end else if (state_q == bal_pkg::ST_SCAN_RD && scan_end && is_del) begin
				used_q <= wr_q;
			end
		end
	end

	// working registers and result fields
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= cmd_in;
			item_q  <= in_word.item;
			tgt_q   <= start_tgt;
			idx_q   <= (start_state == bal_pkg::ST_INS_RD) ? used_q : '0;
			wr_q    <= '0;
			cnt_q   <= '0;
			found_q <= 1'b0;
			value_q <= '0;
			ok_q    <= (cmd_in == bal_pkg::CMD_DEL_REAR) && (used_q != '0);
		end else begin
			unique case (state_q)
				bal_pkg::ST_INS_RD: begin
					if (idx_q == tgt_q) ok_q <= 1'b1;
				end
				bal_pkg::ST_INS_WR: begin
					if (is_sorted && !rd_gt) begin
						ok_q <= 1'b1;
					end else begin
						idx_q <= idx_dec;
					end
				end
				bal_pkg::ST_SCAN_RD: begin
					if (scan_end) begin
						case (cmd_q) inside
							bal_pkg::CMD_DEL_FIRST, bal_pkg::CMD_DEL_ALL,
							bal_pkg::CMD_SEARCH: ok_q <= found_q;
							default:             ok_q <= 1'b1;
						endcase
					end
				end
				bal_pkg::ST_SCAN_EV: begin
					if (rd_match) begin
						found_q <= 1'b1;
						cnt_q   <= cnt_q + bal_pkg::len_t'(1);
					end
					if (!drop) wr_q <= wr_q + bal_pkg::len_t'(1);
					idx_q <= idx_q + bal_pkg::len_t'(1);
				end
				bal_pkg::ST_READ_EV: begin
					ok_q    <= 1'b1;
					value_q <= mem_rdata;
				end
				bal_pkg::ST_IDLE, bal_pkg::ST_READ_RD, bal_pkg::ST_DONE: ;
			endcase
		end
	end

	// assemble the result word
	always_comb begin
		res_word             = '0;
		res_word.ok          = ok_q;
		res_word.found       = found_out && found_q;
		res_word.value       = value_q;
		res_word.match_count = cnt_out ? bal_pkg::cnt_out_t'(cnt_q) : '0;
		res_word.length      = bal_pkg::cnt_out_t'(used_q);
	end

	`BALE_ASSERT_NEVER(a_used_bound, used_q > bal_pkg::len_t'(bal_pkg::MAX_ENTRIES), "length past store depth")
	`BALE_ASSERT(a_write_state, mem_req.we |-> (state_q == bal_pkg::ST_INS_RD || state_q == bal_pkg::ST_INS_WR || state_q == bal_pkg::ST_SCAN_EV), "store written outside a walk")
	`BALE_ASSERT(a_compact_order, (state_q == bal_pkg::ST_SCAN_RD || state_q == bal_pkg::ST_SCAN_EV) |-> (wr_q <= idx_q), "compaction target passed scan index")
	`BALE_ASSERT(a_accept_leaves_idle, accept |=> (state_q != bal_pkg::ST_IDLE), "accepted word left engine idle")
	`BALE_ASSERT(a_done_holds, (state_q == bal_pkg::ST_DONE && !res_free) |=> (state_q == bal_pkg::ST_DONE), "result dropped while output full")

endmodule

// ===== hdl/bounded_array_list_engine.sv =====
// Bounded ordered list of signed 32-bit entries kept packed from position 0.
// Input channel: in_valid / in_stall carry one command word (command, item,
// position); a word is taken on a clock edge with in_valid high and in_stall
// low. Output channel: out_valid / out_stall carry one result word per
// command (ok, found, value, match_count, length).
// cfg_we writes cfg_data into the capacity register; write it only while idle.
// Timing: the engine handles one command at a time. Every entry it walks costs
// a read step and a step that evaluates it; inserts and deletes write the
// entry back to the store (a delete skips the entries it drops). Inserts walk
// the entries they shift, a sorted insert stopping when it meets an entry not
// greater than its item; other deletes, search and count walk the whole list.
// Read at reads a single entry; delete rear and words refused up front go
// straight to the result. The next word is taken in the cycle after the
// result word leaves the engine.
// The result sits in an output register; the engine takes the next command
// while that register waits, and holds its own finished result when
// out_stall keeps the register full.
// Reset empties the list and sets capacity to 64; the store itself is not
// cleared, as only positions below the length are ever read.
module bounded_array_list_engine (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  bal_pkg::in_word_t    in_word,
	output logic                 out_valid,
	input  logic                 out_stall,
	output bal_pkg::out_word_t   out_word,
	input  logic                 cfg_we,
	input  bal_pkg::cap_t        cfg_data
);

	bal_pkg::cap_t      cap_q;
	bal_pkg::mem_req_t  mem_req;
	bal_pkg::data_t     mem_rdata;
	logic               res_valid;
	logic               res_free;
	bal_pkg::out_word_t res_word;
	logic               out_valid_q;
	bal_pkg::out_word_t out_word_q;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= bal_pkg::CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_data;
		end
	end

	bal_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.capacity  (cap_q),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata),
		.res_valid (res_valid),
		.res_free  (res_free),
		.res_word  (res_word)
	);

	bal_ram #(
		.WIDTH (bal_pkg::DATA_W),
		.DEPTH (bal_pkg::MAX_ENTRIES)
	) u_store (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.raddr (mem_req.raddr),
		.rdata (mem_rdata)
	);

	// output register: load when empty or being drained
	assign res_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_free) begin
			out_word_q <= res_word;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule
